@@ sv/scpa_pkg.sv @@
// shared types, constants and helper functions of the size-class pool allocator
// used by size_class_pool_allocator; no dependencies
`default_nettype none

package scpa_pkg;

    localparam int NUM_CLASSES      = 8;
    localparam int BLOCKS_PER_CLASS = 64;
    localparam int POOL_BLOCKS      = NUM_CLASSES * BLOCKS_PER_CLASS;

    // field widths of the word format
    localparam int ACTION_W = 2;
    localparam int SIZE_W   = 16;
    localparam int KIND_W   = 2;
    localparam int CLS_W    = 3;
    localparam int BLK_W    = 6;
    localparam int STATUS_W = 3;
    localparam int BYTES_W  = 12;
    localparam int COUNT_W  = 7;
    localparam int TOTAL_W  = 64;
    localparam int USAGE_W  = 21;
    localparam int NULL_W   = 32;

    localparam int SLOT_W   = CLS_W + BLK_W;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;

    // handle kinds
    localparam logic [KIND_W-1:0] KIND_NULL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POOL = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NULL       = 3'd1,
        ST_OVERSIZE   = 3'd2,
        ST_EXHAUSTED  = 3'd3,
        ST_FOREIGN    = 3'd4,
        ST_NOT_IN_USE = 3'd5
    } status_t;

    // what the execute cycle has to do with a word
    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_QUERY,
        OP_FIXED
    } op_t;

    typedef struct packed {
        logic             hit;
        logic [CLS_W-1:0] cls;
    } class_sel_t;

    // block size of a class: 16 bytes doubled per class
    function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
        class_bytes = BYTES_W'(16) << c;
    endfunction

    // smallest class whose block holds size
    function automatic class_sel_t class_of(input logic [SIZE_W-1:0] size);
        class_sel_t sel;
        sel.hit = 1'b0;
        sel.cls = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (size <= SIZE_W'(class_bytes(CLS_W'(c))))
            begin
                sel.hit = 1'b1;
                sel.cls = CLS_W'(c);
            end
        end
        return sel;
    endfunction

endpackage

`default_nettype wire

@@ sv/scpa_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module scpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/size_class_pool_allocator.sv @@
// top level of the size-class pool allocator: decode, stack and in-use update
// depends on scpa_pkg and scpa_ram
`default_nettype none

// usage
//   input channel (in_valid / in_stall) carries one request word: allocate,
//   free or query. output channel (out_valid / out_stall) returns exactly
//   one result word per request, in order.
//   a request is decoded on the edge that accepts it and its memory reads
//   are launched then; in the execute state the read data is back, the stack,
//   in-use row and counters are written and the result lands in the output
//   register. out_valid rises on the edge that loads the result. a new word
//   is taken only after the last one has executed, set by the read-modify-write
//   of the free-stack ram and the in-use ram.
//   in_stall stays high during the execute cycle; while a result waits under
//   out_stall the next word is still accepted and its execute cycle holds
//   until the output register frees, so nothing is dropped or repeated.
//   reset (rst_n low, asynchronous) clears control and counters. no clearing
//   pass runs: per class a high-water mark tells which stack slots were ever
//   pushed (unwritten slots read as their own index) and one valid bit per
//   in-use row makes unwritten rows read as all free, so requests are taken
//   as soon as reset is released.
//   granted_bytes, live_bytes, live_bytes_max and null_count come straight
//   from the counter registers, which only move when a result is loaded.

module size_class_pool_allocator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // request channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [scpa_pkg::ACTION_W-1:0]    action,
    input  wire logic [scpa_pkg::SIZE_W-1:0]      size,
    input  wire logic [scpa_pkg::KIND_W-1:0]      handle_kind,
    input  wire logic [scpa_pkg::CLS_W-1:0]       handle_class,
    input  wire logic [scpa_pkg::BLK_W-1:0]       handle_block,
    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [scpa_pkg::STATUS_W-1:0]         status,
    output logic [scpa_pkg::CLS_W-1:0]            class_index,
    output logic [scpa_pkg::BLK_W-1:0]            block_index,
    output logic [scpa_pkg::BYTES_W-1:0]          block_bytes,
    output logic [scpa_pkg::COUNT_W-1:0]          class_free_count,
    output logic [scpa_pkg::TOTAL_W-1:0]          granted_bytes,
    output logic [scpa_pkg::USAGE_W-1:0]          live_bytes,
    output logic [scpa_pkg::USAGE_W-1:0]          live_bytes_max,
    output logic [scpa_pkg::NULL_W-1:0]           null_count
);

    import scpa_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BLOCKS_PER_CLASS);

    // control
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // per-class stack pointers and high-water marks
    logic [COUNT_W-1:0] top_reg [NUM_CLASSES];
    logic [COUNT_W-1:0] hw_reg  [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] row_valid_reg;

    // counters
    logic [TOTAL_W-1:0] alloc_total_reg, alloc_total_next;
    logic [USAGE_W-1:0] usage_reg, usage_next;
    logic [USAGE_W-1:0] peak_reg, peak_next;
    logic [NULL_W-1:0]  null_reg, null_next;

    // word held between decode and execute
    op_t                op_reg, op_next;
    status_t            pre_status_reg, pre_status_next;
    logic [CLS_W-1:0]   cls_reg, cls_next;
    logic [BLK_W-1:0]   blk_reg, blk_next;
    logic [COUNT_W-1:0] top_cur_reg, hw_cur_reg;
    logic               row_valid_cur_reg;

    // result register
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CLS_W-1:0]    class_reg, class_next;
    logic [BLK_W-1:0]    block_reg, block_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [COUNT_W-1:0]  fcount_reg, fcount_next;

    // memory ports
    logic                        stack_wr_en;
    logic [SLOT_W-1:0]           stack_wr_addr;
    logic [SLOT_W-1:0]           stack_rd_addr;
    logic [BLK_W-1:0]            stack_rd_data;
    logic                        row_wr_en;
    logic [BLOCKS_PER_CLASS-1:0] row_wr_data;
    logic [BLOCKS_PER_CLASS-1:0] row_rd_data;

    // decode and execute helpers
    logic                        accept;
    logic                        exec_go;
    class_sel_t                  sel;
    logic [BYTES_W-1:0]          exec_bytes;
    logic [BLOCKS_PER_CLASS-1:0] row_cur;
    logic [BLK_W-1:0]            pop_block;
    logic                        top_write;
    logic [COUNT_W-1:0]          top_new;
    logic [COUNT_W-1:0]          hw_new;

    assign accept  = in_valid && (state_reg == S_IDLE);
    assign exec_go = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign class_index      = class_reg;
    assign block_index      = block_reg;
    assign block_bytes      = bytes_reg;
    assign class_free_count = fcount_reg;
    assign granted_bytes    = alloc_total_reg;
    assign live_bytes       = usage_reg;
    assign live_bytes_max   = peak_reg;
    assign null_count       = null_reg;

    // free-index stacks of all classes, slot address is {class, depth}
    scpa_ram #(
        .WIDTH (BLK_W),
        .DEPTH (POOL_BLOCKS)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stack_wr_en),
        .wr_addr (stack_wr_addr),
        .wr_data (blk_reg),
        .rd_en   (accept),
        .rd_addr (stack_rd_addr),
        .rd_data (stack_rd_data)
    );

    // in-use flags, one row per class
    scpa_ram #(
        .WIDTH (BLOCKS_PER_CLASS),
        .DEPTH (NUM_CLASSES)
    ) u_in_use_ram (
        .clk     (clk),
        .wr_en   (row_wr_en),
        .wr_addr (cls_reg),
        .wr_data (row_wr_data),
        .rd_en   (accept),
        .rd_addr (cls_next),
        .rd_data (row_rd_data)
    );

    // decode of the incoming word
    always_comb
    begin
        sel             = class_of(size);
        op_next         = OP_FIXED;
        pre_status_next = ST_OK;
        cls_next        = sel.cls;
        blk_next        = '0;
        if (action == ACT_ALLOC)
        begin
            if (size == '0)
            begin
                pre_status_next = ST_NULL;
            end
            else if (!sel.hit)
            begin
                pre_status_next = ST_OVERSIZE;
            end
            else
            begin
                op_next = OP_ALLOC;
            end
        end
        else if (action == ACT_FREE)
        begin
            cls_next = handle_class;
            blk_next = handle_block;
            if (handle_kind == KIND_NULL)
            begin
                pre_status_next = ST_NULL;
            end
            else if (handle_kind != KIND_POOL
                     || {1'b0, handle_class} >= (CLS_W + 1)'(NUM_CLASSES)
                     || {1'b0, handle_block} >= (BLK_W + 1)'(BLOCKS_PER_CLASS))
            begin
                pre_status_next = ST_FOREIGN;
            end
            else
            begin
                op_next = OP_FREE;
            end
        end
        else
        begin
            // query, unused action code behaves the same
            if (!sel.hit)
            begin
                pre_status_next = ST_OVERSIZE;
            end
            else
            begin
                op_next = OP_QUERY;
            end
        end
        stack_rd_addr = {cls_next, top_reg[cls_next][BLK_W-1:0]};
    end

    // execute: modify the read data and prepare the write-back
    always_comb
    begin
        exec_bytes       = class_bytes(cls_reg);
        row_cur          = row_valid_cur_reg ? row_rd_data : '0;
        // slots at or above the high-water mark were never pushed
        pop_block        = (top_cur_reg < hw_cur_reg) ? stack_rd_data
                                                       : top_cur_reg[BLK_W-1:0];
        top_new          = top_cur_reg;
        top_write        = 1'b0;
        stack_wr_en      = 1'b0;
        stack_wr_addr    = {cls_reg, top_cur_reg[BLK_W-1:0] - BLK_W'(1)};
        row_wr_en        = 1'b0;
        row_wr_data      = row_cur;
        alloc_total_next = alloc_total_reg;
        usage_next       = usage_reg;
        peak_next        = peak_reg;
        null_next        = null_reg;
        status_next      = pre_status_reg;
        class_next       = '0;
        block_next       = '0;
        bytes_next       = '0;
        fcount_next      = '0;

        unique case (op_reg)
            OP_ALLOC:
            begin
                class_next = cls_reg;
                bytes_next = exec_bytes;
                if (top_cur_reg >= FULL_COUNT)
                begin
                    status_next = ST_EXHAUSTED;
                end
                else
                begin
                    top_new          = top_cur_reg + COUNT_W'(1);
                    top_write        = 1'b1;
                    row_wr_en        = 1'b1;
                    row_wr_data      = row_cur | (BLOCKS_PER_CLASS'(1) << pop_block);
                    block_next       = pop_block;
                    alloc_total_next = alloc_total_reg + TOTAL_W'(exec_bytes);
                    usage_next       = usage_reg + USAGE_W'(exec_bytes);
                    if (usage_next > peak_reg)
                    begin
                        peak_next = usage_next;
                    end
                end
                fcount_next = FULL_COUNT - top_new;
            end
            OP_FREE:
            begin
                class_next = cls_reg;
                block_next = blk_reg;
                bytes_next = exec_bytes;
                if (!row_cur[blk_reg] || top_cur_reg == '0)
                begin
                    status_next = ST_NOT_IN_USE;
                end
                else
                begin
                    top_new     = top_cur_reg - COUNT_W'(1);
                    top_write   = 1'b1;
                    stack_wr_en = 1'b1;
                    row_wr_en   = 1'b1;
                    row_wr_data = row_cur & ~(BLOCKS_PER_CLASS'(1) << blk_reg);
                    usage_next  = usage_reg - USAGE_W'(exec_bytes);
                end
                fcount_next = FULL_COUNT - top_new;
            end
            OP_QUERY:
            begin
                class_next  = cls_reg;
                bytes_next  = exec_bytes;
                fcount_next = FULL_COUNT - top_cur_reg;
            end
            default:
            begin
                if (pre_status_reg == ST_NULL)
                begin
                    null_next = null_reg + NULL_W'(1);
                end
            end
        endcase

        hw_new = (top_new > hw_cur_reg) ? top_new : hw_cur_reg;

        // writes only take effect on the cycle the result is loaded
        stack_wr_en = stack_wr_en && exec_go;
        row_wr_en   = row_wr_en && exec_go;
    end

    // sequencing
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
            row_valid_reg     <= '0;
            alloc_total_reg   <= '0;
            usage_reg         <= '0;
            peak_reg          <= '0;
            null_reg          <= '0;
            op_reg            <= OP_FIXED;
            pre_status_reg    <= ST_OK;
            cls_reg           <= '0;
            blk_reg           <= '0;
            top_cur_reg       <= '0;
            hw_cur_reg        <= '0;
            row_valid_cur_reg <= 1'b0;
            status_reg        <= '0;
            class_reg         <= '0;
            block_reg         <= '0;
            bytes_reg         <= '0;
            fcount_reg        <= '0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                top_reg[c] <= '0;
                hw_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                op_reg            <= op_next;
                pre_status_reg    <= pre_status_next;
                cls_reg           <= cls_next;
                blk_reg           <= blk_next;
                top_cur_reg       <= top_reg[cls_next];
                hw_cur_reg        <= hw_reg[cls_next];
                row_valid_cur_reg <= row_valid_reg[cls_next];
            end
            if (exec_go)
            begin
                alloc_total_reg <= alloc_total_next;
                usage_reg       <= usage_next;
                peak_reg        <= peak_next;
                null_reg        <= null_next;
                status_reg      <= status_next;
                class_reg       <= class_next;
                block_reg       <= block_next;
                bytes_reg       <= bytes_next;
                fcount_reg      <= fcount_next;
                if (top_write)
                begin
                    top_reg[cls_reg] <= top_new;
                    hw_reg[cls_reg]  <= hw_new;
                end
                if (row_wr_en)
                begin
                    row_valid_reg[cls_reg] <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire
